// ===== src/wvcc_pkg.sv =====
package wvcc_pkg;

  localparam int COORD_W      = 24;
  localparam int ANGLE_W      = 16;
  localparam int ID_W         = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int DEF_ID_BITS  = 10;
  localparam int DEF_ANGLE_IT = 16;
  localparam int ATAN_LEN     = 24;

  // cordic working widths
  localparam int CW = 36;   // x and y
  localparam int ZW = 25;   // angle accumulator, 1/32768 degree

  localparam int FULL_TURN = 46080;
  localparam int HALF_TURN = 23040;
  localparam int QUARTER_Z = 90 * 32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PORTAL_ACT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PORTAL_S    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PORTAL_E    = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [ID_W-1:0]           start_id;
    logic [ID_W-1:0]           end_id;
    logic                      last_wall;
  } wall_t;

  typedef struct packed {
    logic                      visible;
    logic signed [ANGLE_W-1:0] start_angle;
    logic signed [ANGLE_W-1:0] end_angle;
    logic                      start_in_view;
    logic                      end_in_view;
    logic                      last;
  } result_t;

  // view settings shared by the lanes and the merge stage
  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic [ANGLE_W-1:0]        heading;
    logic signed [ANGLE_W-1:0] bl;
    logic signed [ANGLE_W-1:0] br;
  } view_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 25'sd1474560;
      5'd1:    r = 25'sd870484;
      5'd2:    r = 25'sd459940;
      5'd3:    r = 25'sd233473;
      5'd4:    r = 25'sd117189;
      5'd5:    r = 25'sd58653;
      5'd6:    r = 25'sd29333;
      5'd7:    r = 25'sd14667;
      5'd8:    r = 25'sd7334;
      5'd9:    r = 25'sd3667;
      5'd10:   r = 25'sd1833;
      5'd11:   r = 25'sd917;
      5'd12:   r = 25'sd458;
      5'd13:   r = 25'sd229;
      5'd14:   r = 25'sd115;
      5'd15:   r = 25'sd57;
      5'd16:   r = 25'sd29;
      5'd17:   r = 25'sd14;
      5'd18:   r = 25'sd7;
      5'd19:   r = 25'sd4;
      5'd20:   r = 25'sd2;
      5'd21:   r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/wall_view_cone_culler_top.sv =====
// Wall view cone culler: takes one wall per cycle and returns one result
// per wall, in order. Each wall endpoint has its own CORDIC lane
// (ANGLE_ITERATIONS registered vectoring stages, capped at 24, plus an entry
// and a wrap stage); a merge stage decides visibility. The pipeline holds
// as a whole while a result is stalled; bounds and viewer registers must
// only be written while idle.
module wall_view_cone_culler_top import wvcc_pkg::*; #(
  parameter int ID_BITS          = DEF_ID_BITS,
  parameter int ANGLE_ITERATIONS = DEF_ANGLE_IT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wall_valid,
  output logic                  wall_stall,
  input  wall_t                 wall,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int N        = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
  localparam int LANE_LAT = N + 2;
  localparam int LAT      = N + 3;
  localparam int CMP_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  view_t          view;
  logic           portal_active;
  logic [ID_W-1:0] portal_start_id, portal_end_id;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view.vx         <= '0;
      view.vy         <= '0;
      view.heading    <= '0;
      view.bl         <= 16'sd5760;
      view.br         <= -16'sd5760;
      portal_active   <= 1'b0;
      portal_start_id <= '0;
      portal_end_id   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIEWER_X:    view.vx         <= cfg_data;
        REG_VIEWER_Y:    view.vy         <= cfg_data;
        REG_HEADING:     view.heading    <= cfg_data[ANGLE_W-1:0];
        REG_BOUND_LEFT:  view.bl         <= cfg_data[ANGLE_W-1:0];
        REG_BOUND_RIGHT: view.br         <= cfg_data[ANGLE_W-1:0];
        REG_PORTAL_ACT:  portal_active   <= cfg_data[0];
        REG_PORTAL_S:    portal_start_id <= cfg_data[ID_W-1:0];
        REG_PORTAL_E:    portal_end_id   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the output item waits
  logic en;
  assign en         = !(result_valid && result_stall);
  assign wall_stall = !en;

  logic vld [0:LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= wall_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end
  assign result_valid = vld[LAT-1];

  // portal id matches
  logic [CMP_BITS-1:0] sid, eid, ps, pe;
  logic s_hit, e_hit, hidden;
  always_comb begin
    sid    = wall.start_id[CMP_BITS-1:0];
    eid    = wall.end_id[CMP_BITS-1:0];
    ps     = portal_start_id[CMP_BITS-1:0];
    pe     = portal_end_id[CMP_BITS-1:0];
    s_hit  = portal_active && (sid == ps || sid == pe);
    e_hit  = portal_active && (eid == ps || eid == pe);
    hidden = portal_active && ((sid == ps && eid == pe) || (sid == pe && eid == ps));
  end

  logic signed [ANGLE_W-1:0] sa, ea;
  logic siv, eiv;

  wvcc_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_lane_start (
    .clk(clk), .en(en), .px(wall.start_x), .py(wall.start_y),
    .portal_hit(s_hit), .view(view), .angle(sa), .in_view(siv)
  );

  wvcc_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_lane_end (
    .clk(clk), .en(en), .px(wall.end_x), .py(wall.end_y),
    .portal_hit(e_hit), .view(view), .angle(ea), .in_view(eiv)
  );

  wvcc_merge #(.DEPTH(LANE_LAT)) u_merge (
    .clk(clk), .en(en), .hidden_in(hidden), .last_in(wall.last_wall),
    .sa(sa), .ea(ea), .siv(siv), .eiv(eiv), .bl(view.bl), .result(result)
  );

endmodule

// ===== src/wvcc_lane.sv =====
module wvcc_lane import wvcc_pkg::*; #(
  parameter int ANGLE_ITERATIONS = DEF_ANGLE_IT
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic                      portal_hit,
  input  view_t                     view,
  output logic signed [ANGLE_W-1:0] angle,
  output logic                      in_view
);

  localparam int N = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;

  logic signed [CW-1:0] x [0:N];
  logic signed [CW-1:0] y [0:N];
  logic signed [ZW-1:0] z [0:N];
  logic                 zero [0:N];
  logic                 hit [0:N];

  logic signed [COORD_W:0] dx, dy;
  logic signed [CW-1:0]    x0, y0;

  // difference from the viewer and coarse quarter turn
  assign dx = {px[COORD_W-1], px} - {view.vx[COORD_W-1], view.vx};
  assign dy = {py[COORD_W-1], py} - {view.vy[COORD_W-1], view.vy};
  assign x0 = CW'(dx) <<< 8;
  assign y0 = CW'(dy) <<< 8;

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (dx == '0) && (dy == '0);
      hit[0]  <= portal_hit;
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x[0] <= y0;
          y[0] <= -x0;
          z[0] <= ZW'(QUARTER_Z);
        end else begin
          x[0] <= -y0;
          y[0] <= x0;
          z[0] <= -ZW'(QUARTER_Z);
        end
      end else begin
        x[0] <= x0;
        y[0] <= y0;
        z[0] <= '0;
      end
    end
  end

  // one vectoring step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        hit[i+1]  <= hit[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_step(5'(i));
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_step(5'(i));
        end
      end
    end
  end

  // round, remove heading, wrap into the half turn
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   a;
  logic signed [18:0]   t, w;
  logic signed [ANGLE_W-1:0] r;

  always_comb begin
    zr = z[N] + ZW'(128);
    a  = zero[N] ? 17'sd0 : 17'(zr >>> 8);
    t  = 19'(a) - 19'($signed({1'b0, view.heading})) + 19'sd92160;
    if (t >= 19'sd92160)      w = t - 19'sd92160;
    else if (t >= 19'sd46080) w = t - 19'sd46080;
    else                      w = t;
    if (w > 19'(HALF_TURN)) r = ANGLE_W'(w - 19'(FULL_TURN));
    else                    r = ANGLE_W'(w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= r;
      in_view <= (r >= view.br) && (r <= view.bl) && !hit[N];
    end
  end

endmodule

// ===== src/wvcc_merge.sv =====
module wvcc_merge import wvcc_pkg::*; #(
  parameter int DEPTH = DEF_ANGLE_IT + 2
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      hidden_in,
  input  logic                      last_in,
  input  logic signed [ANGLE_W-1:0] sa,
  input  logic signed [ANGLE_W-1:0] ea,
  input  logic                      siv,
  input  logic                      eiv,
  input  logic signed [ANGLE_W-1:0] bl,
  output result_t                   result
);

  logic hid [0:DEPTH-1];
  logic lst [0:DEPTH-1];

  // wall-level flags follow the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      hid[0] <= hidden_in;
      lst[0] <= last_in;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        hid[i] <= hid[i-1];
        lst[i] <= lst[i-1];
      end
    end
  end

  // angles measured from the left bound, then the span test
  logic signed [18:0] fs, fe, d;
  logic               spans;

  always_comb begin
    fs = 19'(sa) - 19'(bl);
    fe = 19'(ea) - 19'(bl);
    if (fs < 0) fs = fs + 19'(FULL_TURN);
    if (fe < 0) fe = fe + 19'(FULL_TURN);
    d     = fe - fs;
    spans = (d > 19'(HALF_TURN)) || (d < -19'(HALF_TURN));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.visible       <= (siv || eiv || spans) && !hid[DEPTH-1];
      result.start_angle   <= sa;
      result.end_angle     <= ea;
      result.start_in_view <= siv;
      result.end_in_view   <= eiv;
      result.last          <= lst[DEPTH-1];
    end
  end

endmodule

// ===== src/wvcc_checker.sv =====
module wvcc_checker import wvcc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    wall_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // nothing comes out in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // input is held back only by a stalled result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    wall_stall |-> (result_valid && result_stall))
    else $error("input stalled without output back pressure");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // angles stay within the half turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.start_angle >= -16'sd23040 && result.start_angle <= 16'sd23040
                   && result.end_angle >= -16'sd23040 && result.end_angle <= 16'sd23040))
    else $error("angle out of range");

endmodule

bind wall_view_cone_culler_top wvcc_checker u_wvcc_checker (
  .clk(clk), .rst(rst), .wall_stall(wall_stall), .result_valid(result_valid),
  .result_stall(result_stall), .result(result)
);
